FILE: rtl/core/lrut_pkg.sv
// Shared types, sizes and codes for the LRU replacement tracker.
package lrut_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVICT  = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } stat_e_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LOOK  = 2'd1,
    S_APPLY = 2'd2
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;  // capture an accepted input beat
    logic lookup;   // register the key match result
    logic apply;    // update the order and load the output register
  } dp_cmd_t;

endpackage

FILE: rtl/core/lrut_datapath.sv
// Datapath: key order store, parallel key match, order update, result register.
module lrut_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lrut_pkg::dp_cmd_t cmd,
  input  logic [1:0]        in_command,
  input  lrut_pkg::key_t    in_key,
  output logic [1:0]        out_status,
  output lrut_pkg::key_t    out_evicted_key
);

  lrut_pkg::key_t    keys [lrut_pkg::CAPACITY];
  lrut_pkg::cnt_t    live_count;
  lrut_pkg::cnt_t    live_count_next;
  lrut_pkg::cmd_e_t  op;
  lrut_pkg::key_t    key_q;
  logic              hit;
  lrut_pkg::idx_t    pos;
  logic              found;
  lrut_pkg::idx_t    found_pos;
  logic              shift_en;
  lrut_pkg::idx_t    shift_pos;
  logic              wr_en;
  lrut_pkg::idx_t    wr_slot;
  lrut_pkg::stat_e_t st;
  lrut_pkg::key_t    ev;
  lrut_pkg::stat_e_t status_q;
  lrut_pkg::key_t    evicted_q;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= lrut_pkg::cmd_e_t'(in_command);
      key_q <= in_key;
    end
  end

  // Compare the key against every live slot in parallel
  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = lrut_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (lrut_pkg::cnt_t'(i) < live_count && keys[i] == key_q) begin
        found     = 1'b1;
        found_pos = lrut_pkg::idx_t'(i);
      end
    end
  end

  // Hold the match result for the update step
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit <= found;
      pos <= found_pos;
    end
  end

  // Decide the update: drop a slot, write the newest slot, adjust the count
  always_comb begin
    shift_en        = 1'b0;
    shift_pos       = pos;
    wr_en           = 1'b0;
    wr_slot         = lrut_pkg::idx_t'(live_count);
    live_count_next = live_count;
    st              = lrut_pkg::STAT_DONE;
    ev              = '0;
    case (op)
      lrut_pkg::CMD_EVICT: begin
        if (live_count == '0) begin
          st = lrut_pkg::STAT_EMPTY;
        end else begin
          ev              = keys[0];
          shift_en        = 1'b1;
          shift_pos       = '0;
          live_count_next = live_count - lrut_pkg::cnt_t'(1);
        end
      end
      lrut_pkg::CMD_PUT: begin
        if (hit) begin
          shift_en = 1'b1;
          wr_en    = 1'b1;
          wr_slot  = lrut_pkg::idx_t'(live_count - lrut_pkg::cnt_t'(1));
        end else if (live_count == lrut_pkg::cnt_t'(lrut_pkg::CAPACITY)) begin
          st = lrut_pkg::STAT_FULL;
        end else begin
          wr_en           = 1'b1;
          live_count_next = live_count + lrut_pkg::cnt_t'(1);
        end
      end
      lrut_pkg::CMD_GET: begin
        if (hit) begin
          shift_en = 1'b1;
          wr_en    = 1'b1;
          wr_slot  = lrut_pkg::idx_t'(live_count - lrut_pkg::cnt_t'(1));
        end else begin
          st = lrut_pkg::STAT_ABSENT;
        end
      end
      lrut_pkg::CMD_REMOVE: begin
        if (hit) begin
          shift_en        = 1'b1;
          live_count_next = live_count - lrut_pkg::cnt_t'(1);
        end else begin
          st = lrut_pkg::STAT_ABSENT;
        end
      end
      default: begin
        st = lrut_pkg::STAT_DONE;
      end
    endcase
  end

  // Shift newer keys one slot older, then write the newest slot
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < lrut_pkg::CAPACITY; i++) begin
        if (shift_en && lrut_pkg::idx_t'(i) >= shift_pos &&
            lrut_pkg::cnt_t'(i + 1) < live_count) begin
          keys[i] <= keys[(i + 1) % lrut_pkg::CAPACITY];
        end
        if (wr_en && lrut_pkg::idx_t'(i) == wr_slot) begin
          keys[i] <= key_q;
        end
      end
    end
  end

  // Advance the live count
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (cmd.apply) begin
      live_count <= live_count_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_q  <= st;
      evicted_q <= ev;
    end
  end

  assign out_status      = status_q;
  assign out_evicted_key = evicted_q;

endmodule

FILE: rtl/core/lrut_ctrl.sv
// Controller: sequences lookup and update, and owns the handshakes.
module lrut_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lrut_pkg::dp_cmd_t cmd
);

  lrut_pkg::state_t state;
  lrut_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrut_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      lrut_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = lrut_pkg::S_LOOK;
        end
      end
      lrut_pkg::S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = lrut_pkg::S_APPLY;
      end
      lrut_pkg::S_APPLY: begin
        if (out_free) begin
          cmd.apply = 1'b1;
          in_ready  = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = lrut_pkg::S_LOOK;
          end else begin
            state_next = lrut_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = lrut_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.apply || (out_valid && !out_ready);
    end
  end

endmodule

FILE: rtl/core/lru_replacement_tracker.sv
// Top level of the LRU replacement tracker.
//
// Keeps the use order of up to 16 distinct 32-bit keys, oldest to newest.
// Input stream (s_axis): one beat per command, put, get, remove or evict
// oldest. Output stream (m_axis): exactly one beat per command, carrying a
// status code and, for a successful evict, the evicted key (zero otherwise).
// After acceptance each command runs a match step, comparing the key against
// all live slots in parallel, then an update step, shifting the order and
// writing the newest slot. The result appears on m_axis the cycle after the
// update, and back-to-back commands are paced by the match-then-update steps.
// The next command is accepted in the update cycle, as the new result enters
// the output register. When the receiver stalls, the result register holds
// and the block finishes at most one more command up to its update step,
// then waits there; s_axis_tready drops until the output beat is taken.
// Synchronous reset empties the tracker (live count zero), clears the output
// valid flag and returns the controller to idle; no clearing pass is needed.
module lru_replacement_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [1:0] command, [33:2] key, [39:34] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] evicted_key, [39:34] zero
);

  lrut_pkg::dp_cmd_t cmd;
  logic [1:0]        status;
  lrut_pkg::key_t    evicted_key;

  lrut_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  lrut_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_command      (s_axis_tdata[1:0]),
    .in_key          (s_axis_tdata[33:2]),
    .out_status      (status),
    .out_evicted_key (evicted_key)
  );

  // Pack the result beat
  assign m_axis_tdata = {6'd0, evicted_key, status};

endmodule
